### hdl/bfha_pkg.sv
`timescale 1ns / 1ps
package bfha_pkg;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} bfha_cmd_t;

	typedef struct packed {
		logic scan_last;
	} bfha_sts_t;
endpackage

### hdl/bfha_ctrl.sv
`timescale 1ns / 1ps
module bfha_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output bfha_pkg::bfha_cmd_t cmd,
	input  bfha_pkg::bfha_sts_t sts
);
	import bfha_pkg::*;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	logic [1:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_last) state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.scan = (state_q == S_SCAN);
	assign cmd.commit = (state_q == S_COMMIT);

`ifndef SYNTHESIS
	a_commit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |-> $past(state_q == S_SCAN)) else $error("commit without scan");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_SCAN)) else $error("load did not start scan");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan, cmd.commit})) else $error("commands overlap");
`endif
endmodule

### hdl/bfha_dp.sv
`timescale 1ns / 1ps
module bfha_dp #(
	parameter int SEGMENT_BYTES = 65536,
	parameter int HEADER_BYTES = 16,
	parameter int MAX_BLOCKS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  bfha_pkg::bfha_cmd_t cmd,
	output bfha_pkg::bfha_sts_t sts,
	input  logic req_type,
	input  logic [15:0] req_size,
	input  logic [15:0] free_addr,
	output logic done,
	output logic [15:0] payload_addr,
	output logic [1:0] status
);
	import bfha_pkg::*;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [15:0] HDR = 16'(HEADER_BYTES);
	localparam logic [15:0] INIT_SIZE = 16'(SEGMENT_BYTES - HEADER_BYTES);

	logic [15:0] start_q [MAX_BLOCKS];
	logic [15:0] size_q [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] used_q;
	logic [CW-1:0] count_q;
	logic type_q;
	logic [15:0] rsize_q, raddr_q;
	logic [IW-1:0] idx_q, best_q;
	logic found_q;
	logic [15:0] bsize_q;
	logic [16:0] need;

	assign need = {1'b0, rsize_q} + 17'(HEADER_BYTES);
	assign sts.scan_last = ({1'b0, idx_q} + 1'b1) >= CW'(count_q) || (CW'(idx_q) + 1'b1 >= count_q);

	logic hit_a, hit_f;
	assign hit_a = !used_q[idx_q] && {1'b0, size_q[idx_q]} >= need
		&& (!found_q || size_q[idx_q] <= bsize_q);
	assign hit_f = !found_q && (start_q[idx_q] + HDR == raddr_q);

	logic [15:0] nsize;
	logic [IW-1:0] nx;
	logic [15:0] msize;
	logic mnext, mprev;
	always_comb begin
		nsize = bsize_q - need[15:0];
		nx = best_q + 1'b1;
		mnext = (CW'(best_q) + 1'b1 < count_q) && !used_q[nx];
		mprev = (best_q != '0) && !used_q[best_q - 1'b1];
		msize = mnext ? size_q[best_q] + size_q[nx] + HDR : size_q[best_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			count_q <= CW'(1);
			found_q <= 1'b0;
			done <= 1'b0;
			type_q <= 1'b0;
			rsize_q <= '0;
			raddr_q <= '0;
			idx_q <= '0;
			best_q <= '0;
			bsize_q <= '0;
			payload_addr <= '0;
			status <= ST_DONE;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				start_q[i] <= '0;
				size_q[i] <= '0;
			end
			size_q[0] <= INIT_SIZE;
		end else begin
			done <= 1'b0;
			if (cmd.load) begin
				type_q <= req_type;
				rsize_q <= req_size;
				raddr_q <= free_addr;
				idx_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan) begin
				if ((type_q == REQ_ALLOC) ? hit_a : hit_f) begin
					found_q <= 1'b1;
					best_q <= idx_q;
					bsize_q <= size_q[idx_q];
				end
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.commit) begin
				done <= 1'b1;
				payload_addr <= '0;
				if (type_q == REQ_ALLOC) begin
					if (rsize_q == '0 || count_q >= CW'(MAX_BLOCKS) || !found_q) begin
						status <= ST_NOFIT;
					end else begin
						status <= ST_DONE;
						size_q[best_q] <= nsize;
						for (int i = 1; i < MAX_BLOCKS; i++) begin
							if (IW'(i) > nx && CW'(i) <= count_q) begin
								start_q[i] <= start_q[i-1];
								size_q[i] <= size_q[i-1];
								used_q[i] <= used_q[i-1];
							end
						end
						start_q[nx] <= start_q[best_q] + HDR + nsize;
						size_q[nx] <= rsize_q;
						used_q[nx] <= 1'b1;
						count_q <= count_q + 1'b1;
						payload_addr <= start_q[best_q] + HDR + nsize + HDR;
					end
				end else if (!found_q) begin
					status <= ST_NOTFOUND;
				end else begin
					status <= ST_DONE;
					if (mprev) begin
						size_q[best_q-1'b1] <= size_q[best_q-1'b1] + msize + HDR;
					end else begin
						size_q[best_q] <= msize;
						used_q[best_q] <= 1'b0;
					end
					for (int i = 0; i < MAX_BLOCKS; i++) begin
						if (IW'(i) >= best_q && (mprev || mnext)) begin
							if (mprev && mnext) begin
								if (i + 2 < MAX_BLOCKS && IW'(i) >= best_q) begin
									start_q[i] <= start_q[i+2];
									size_q[i] <= size_q[i+2];
									used_q[i] <= used_q[i+2];
								end
							end else if (mprev) begin
								if (i + 1 < MAX_BLOCKS) begin
									start_q[i] <= start_q[i+1];
									size_q[i] <= size_q[i+1];
									used_q[i] <= used_q[i+1];
								end
							end else if (IW'(i) > best_q && i + 1 < MAX_BLOCKS) begin
								start_q[i] <= start_q[i+1];
								size_q[i] <= size_q[i+1];
								used_q[i] <= used_q[i+1];
							end
						end
					end
					if (mprev && best_q != '0) begin
						size_q[best_q-1'b1] <= size_q[best_q-1'b1] + msize + HDR;
					end
					count_q <= count_q - CW'(mprev) - CW'(mnext);
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(1) && count_q <= CW'(MAX_BLOCKS)) else $error("block count out of range");
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> done) else $error("missing result");
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> payload_addr == '0) else $error("nonzero addr on failure");
`endif
endmodule

### hdl/best_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Best-fit heap allocator over an address-ordered table of blocks.
// Issue a request by raising start with req_type, req_size and free_addr
// while busy is low; the beat is taken at that edge.
// An allocate searches for the smallest free block that fits the request
// plus header, carves the new block from its tail and returns its payload
// offset. A free finds the block by payload offset and merges neighbors.
// The table is scanned one entry per cycle, then the chosen block is
// updated in a commit step; busy stays high throughout.
// The result appears on payload_addr and status with done high for exactly
// one cycle; done rises in the same cycle that busy falls.
// The receiver cannot stall, so it must take the beat then.
// Reset leaves one free block spanning the whole segment.
module best_fit_heap_allocator #(
	parameter int SEGMENT_BYTES = 65536,
	parameter int HEADER_BYTES = 16,
	parameter int MAX_BLOCKS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic req_type,
	input  logic [15:0] req_size,
	input  logic [15:0] free_addr,
	output logic done,
	output logic [15:0] payload_addr,
	output logic [1:0] status
);
	import bfha_pkg::*;
	bfha_cmd_t cmd;
	bfha_sts_t sts;

	bfha_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd, .sts);
	bfha_dp #(.SEGMENT_BYTES(SEGMENT_BYTES), .HEADER_BYTES(HEADER_BYTES),
		.MAX_BLOCKS(MAX_BLOCKS)) u_dp (.clk, .arst_n, .cmd, .sts, .req_type,
		.req_size, .free_addr, .done, .payload_addr, .status);
endmodule

### bench/tb_best_fit_heap_allocator.sv
`timescale 1ns / 1ps
module tb_best_fit_heap_allocator;
	import bfha_pkg::*;

	localparam int SEG = 65536;
	localparam int HDR = 16;
	localparam int NBLK = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [15:0] payload_addr;
		logic [1:0] status;
	} heap_result_t;

	class heap_scoreboard;
		int unsigned blk_start[NBLK];
		int unsigned blk_size[NBLK];
		bit blk_used[NBLK];
		int unsigned blk_count;
		heap_result_t pending[$];
		int errors;

		function void clear();
			int j;
			for (j = 0; j < NBLK; j++) begin
				blk_start[j] = 0;
				blk_size[j] = 0;
				blk_used[j] = 0;
			end
			blk_size[0] = SEG - HDR;
			blk_count = 1;
			errors = 0;
		endfunction

		function void remove_entry(int unsigned k);
			int unsigned j;
			for (j = k; j + 1 < blk_count; j++) begin
				blk_start[j] = blk_start[j + 1];
				blk_size[j] = blk_size[j + 1];
				blk_used[j] = blk_used[j + 1];
			end
			blk_count--;
		endfunction

		function void note_request(logic rtype, logic [15:0] rsize, logic [15:0] faddr);
			heap_result_t r;
			int unsigned need, best, best_size, j, k;
			bit found;
			r.payload_addr = 0;
			r.status = ST_DONE;
			found = 0;
			best = 0;
			best_size = 0;
			k = 0;
			if (rtype == REQ_ALLOC) begin
				need = rsize + HDR;
				if (rsize == 0 || blk_count >= NBLK) begin
					r.status = ST_NOFIT;
				end else begin
					for (j = 0; j < blk_count; j++)
						if (!blk_used[j] && blk_size[j] >= need &&
								(!found || blk_size[j] <= best_size)) begin
							found = 1;
							best = j;
							best_size = blk_size[j];
						end
					if (!found) begin
						r.status = ST_NOFIT;
					end else begin
						blk_size[best] = best_size - need;
						for (j = blk_count; j > best + 1; j--) begin
							blk_start[j] = blk_start[j - 1];
							blk_size[j] = blk_size[j - 1];
							blk_used[j] = blk_used[j - 1];
						end
						blk_start[best + 1] = blk_start[best] + HDR + blk_size[best];
						blk_size[best + 1] = rsize;
						blk_used[best + 1] = 1;
						blk_count++;
						r.payload_addr = 16'(blk_start[best + 1] + HDR);
					end
				end
			end else begin
				for (j = 0; j < blk_count; j++)
					if (!found && blk_start[j] + HDR == faddr) begin
						found = 1;
						k = j;
					end
				if (!found) begin
					r.status = ST_NOTFOUND;
				end else begin
					blk_used[k] = 0;
					if (k + 1 < blk_count && !blk_used[k + 1]) begin
						blk_size[k] = (blk_size[k] + blk_size[k + 1] + HDR) & 16'hFFFF;
						remove_entry(k + 1);
					end
					if (k > 0 && !blk_used[k - 1]) begin
						blk_size[k - 1] = (blk_size[k - 1] + blk_size[k] + HDR) & 16'hFFFF;
						remove_entry(k);
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [15:0] addr, logic [1:0] st);
			heap_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result payload_addr %0h status %0d", addr, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (addr !== e.payload_addr) begin
				$error("payload_addr expected %0h actual %0h", e.payload_addr, addr);
				errors++;
			end
			if (st !== e.status) begin
				$error("status expected %0d actual %0d", e.status, st);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic req_type;
	logic [15:0] req_size;
	logic [15:0] free_addr;
	logic done;
	logic [15:0] payload_addr;
	logic [1:0] status;

	heap_scoreboard sb;
	logic [15:0] live_addrs[$];
	int unsigned cycles = 0;

	best_fit_heap_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.req_size(req_size),
		.free_addr(free_addr),
		.done(done),
		.payload_addr(payload_addr),
		.status(status)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		sb = new();
		sb.clear();
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(payload_addr, status);
			if (status == ST_DONE && payload_addr != 0)
				live_addrs.push_back(payload_addr);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_request(logic rtype, logic [15:0] rsize, logic [15:0] faddr, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(16) : 0;
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		req_type <= rtype;
		req_size <= rsize;
		free_addr <= faddr;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(rtype, rsize, faddr);
		start <= 1'b0;
		req_type <= 1'($urandom_range(1));
		req_size <= 16'($urandom);
		free_addr <= 16'($urandom);
		@(posedge clk);
	endtask

	task automatic wait_drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (NBLK + 8) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_live();
		int i;
		logic [15:0] a;
		i = $urandom_range(live_addrs.size() - 1);
		a = live_addrs[i];
		live_addrs.delete(i);
		return a;
	endfunction

	initial begin
		int n, i;
		bit gaps;
		logic [15:0] sz;
		arst_n = 0;
		start = 0;
		req_type = 0;
		req_size = 0;
		free_addr = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_ALLOC, 16'd0, 16'd0, 0);
		send_request(REQ_ALLOC, 16'hFFFF, 16'd0, 0);
		send_request(REQ_ALLOC, 16'd65504, 16'd0, 0);
		send_request(REQ_FREE, 16'd0, 16'hFFFF, 0);
		send_request(REQ_FREE, 16'd0, 16'd16, 0);
		send_request(REQ_FREE, 16'd0, 16'd16, 0);
		for (i = 0; i < 16; i++)
			send_request(REQ_ALLOC, 16'(1 + i), 16'd0, 0);
		wait_drain();
		while (live_addrs.size() > 0)
			send_request(REQ_FREE, 16'd0, pick_live(), 1);
		send_request(REQ_ALLOC, 16'd65519, 16'd0, 0);
		wait_drain();

		n = 0;
		while (n < 1800) begin
			gaps = ($urandom_range(7) != 0);
			for (i = 0; i < 40 && n < 1800; i++, n++) begin
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						sz = ($urandom_range(7) == 0) ? 16'($urandom) :
							16'($urandom_range(4096, 1));
						send_request(REQ_ALLOC, sz, 16'($urandom), gaps);
					end
					4, 5, 6, 7: begin
						if (live_addrs.size() > 0)
							send_request(REQ_FREE, 16'($urandom), pick_live(), gaps);
						else
							send_request(REQ_ALLOC, 16'($urandom_range(300, 1)),
								16'($urandom), gaps);
					end
					default: send_request(1'($urandom_range(1)), 16'($urandom),
						16'($urandom), gaps);
				endcase
				while (sb.pending.size() != 0) @(posedge clk);
			end
		end
		wait_drain();
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

### sim.f
hdl/bfha_pkg.sv
hdl/bfha_ctrl.sv
hdl/bfha_dp.sv
hdl/best_fit_heap_allocator.sv
bench/tb_best_fit_heap_allocator.sv
